FILE: hw/rtl/tbs_pkg.sv
package tbs_pkg;

  localparam int ROM_LEN = 93;
  localparam int IDX_W   = 7;
  localparam int NINFO_W = 25;
  localparam int TOT_W   = 26;
  localparam int NUM_W   = 27;
  localparam int DVS_W   = 17;
  localparam int QUO_W   = 11;
  localparam int OUT_W   = 23;

  localparam logic [OUT_W-1:0] OUT_MAX = 23'h7F_FFFF;

  // Sorted TBS sizes for the quantized small-size path
  localparam logic [11:0] TBS_ROM [0:ROM_LEN-1] = '{
    12'd24, 12'd32, 12'd40, 12'd48, 12'd56, 12'd64, 12'd72, 12'd80, 12'd88, 12'd96,
    12'd104, 12'd112, 12'd120, 12'd128, 12'd136, 12'd144, 12'd152, 12'd160,
    12'd168, 12'd176, 12'd184, 12'd192, 12'd208, 12'd224, 12'd240, 12'd256,
    12'd272, 12'd288, 12'd304, 12'd320, 12'd336, 12'd352, 12'd368, 12'd384,
    12'd408, 12'd432, 12'd456, 12'd480, 12'd504, 12'd528, 12'd552, 12'd576,
    12'd608, 12'd640, 12'd672, 12'd704, 12'd736, 12'd768, 12'd808, 12'd848,
    12'd888, 12'd928, 12'd984, 12'd1032, 12'd1064, 12'd1128, 12'd1160,
    12'd1192, 12'd1224, 12'd1256, 12'd1288, 12'd1320, 12'd1352, 12'd1416,
    12'd1480, 12'd1544, 12'd1608, 12'd1672, 12'd1736, 12'd1800, 12'd1864,
    12'd1928, 12'd2024, 12'd2088, 12'd2152, 12'd2216, 12'd2280, 12'd2408,
    12'd2472, 12'd2536, 12'd2600, 12'd2664, 12'd2728, 12'd2792, 12'd2856,
    12'd2976, 12'd3104, 12'd3240, 12'd3368, 12'd3496, 12'd3624, 12'd3752,
    12'd3824
  };

  // Item state through the code-block divider
  typedef struct packed {
    logic             sm;
    logic [IDX_W-1:0] idx;
    logic [NUM_W-1:0] rem;
    logic [DVS_W-1:0] dvs;
    logic [QUO_W-1:0] quo;
  } div_t;

endpackage

FILE: hw/rtl/tbs_front.sv
module tbs_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [3:0]                   mod_order,
  input  logic [13:0]                  code_rate,
  input  logic [8:0]                   rb_count,
  input  logic [3:0]                   symbol_count,
  input  logic [7:0]                   dmrs_re_per_prb,
  input  logic [5:0]                   overhead_re,
  input  logic [1:0]                   scaling_shift,
  input  logic [3:0]                   layer_count,
  output logic                         out_valid,
  output logic [tbs_pkg::NINFO_W-1:0]  ninfo,
  output logic                         rate_low
);
  import tbs_pkg::*;

  // stage 1: REs per PRB, rate / 5, Qm * layers
  logic [7:0]  re_tot;
  logic [8:0]  cut, re_raw;
  logic [7:0]  re_nxt;
  logic [29:0] rprod;
  logic [7:0]  ql_nxt;

  logic        v1_r, v2_r, v3_r, v4_r;
  logic [7:0]  re_r;
  logic [8:0]  rbs_r;
  logic [11:0] rdiv_r;
  logic [7:0]  ql_r;
  logic [1:0]  sh1_r, sh2_r, sh3_r;
  logic        rl1_r, rl2_r, rl3_r, rl4_r;
  logic [16:0] p1_r;
  logic [19:0] p2_r;
  logic [36:0] prod_r;
  logic [NINFO_W-1:0] ninfo_r;

  always_comb begin
    re_tot = {1'b0, symbol_count, 3'b0} + {2'b0, symbol_count, 2'b0};
    cut    = {1'b0, dmrs_re_per_prb} + {3'b0, overhead_re};
    re_raw = ({1'b0, re_tot} > cut) ? ({1'b0, re_tot} - cut) : 9'd0;
    re_nxt = (re_raw > 9'd156) ? 8'd156 : re_raw[7:0];
    rprod  = {16'b0, code_rate} * 30'd52429;
    ql_nxt = {4'b0, mod_order} * {4'b0, layer_count};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      re_r    <= re_nxt;
      rbs_r   <= rb_count;
      rdiv_r  <= rprod[29:18];
      ql_r    <= ql_nxt;
      sh1_r   <= scaling_shift;
      rl1_r   <= (code_rate <= 14'd2560);
      p1_r    <= {9'b0, re_r} * {8'b0, rbs_r};
      p2_r    <= {8'b0, rdiv_r} * {12'b0, ql_r};
      sh2_r   <= sh1_r;
      rl2_r   <= rl1_r;
      prod_r  <= {20'b0, p1_r} * {17'b0, p2_r};
      sh3_r   <= sh2_r;
      rl3_r   <= rl2_r;
      ninfo_r <= prod_r[35:11] >> sh3_r;
      rl4_r   <= rl3_r;
    end
  end

  assign out_valid = v4_r;
  assign ninfo     = ninfo_r;
  assign rate_low  = rl4_r;

endmodule

FILE: hw/rtl/tbs_quant.sv
module tbs_quant (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [tbs_pkg::NINFO_W-1:0]  ninfo,
  input  logic                         rate_low,
  output logic                         out_valid,
  output tbs_pkg::div_t                out_item
);
  import tbs_pkg::*;

  function automatic logic [4:0] flog2(input logic [NINFO_W-1:0] x);
    logic [4:0] r;
    r = 5'd0;
    for (int i = 0; i < NINFO_W; i++) begin
      if (x[i]) r = 5'(i);
    end
    return r;
  endfunction

  logic v5_r, v6_r, v7_r, v8_r;

  // stage 5: size class and bit lengths
  logic               sm5_r, rl5_r;
  logic [NINFO_W-1:0] ni5_r, base5_r;
  logic [4:0]         lgs5_r, lgl5_r;
  logic [NINFO_W-1:0] base_c;

  assign base_c = ninfo - NINFO_W'(24);

  // stage 6: quantize
  logic [4:0]       ns, nl;
  logic [11:0]      nps_raw, nps_nxt;
  logic [TOT_W-1:0] half, rnd, npl_raw, npl_nxt;
  logic             sm6_r, rl6_r, big6_r;
  logic [11:0]      nps6_r;
  logic [TOT_W-1:0] tot6_r;

  always_comb begin
    ns      = (lgs5_r > 5'd9) ? (lgs5_r - 5'd6) : 5'd3;
    nps_raw = (ni5_r[11:0] >> ns) << ns;
    nps_nxt = (nps_raw < 12'd24) ? 12'd24 : nps_raw;
    nl      = lgl5_r - 5'd5;
    half    = TOT_W'(1) << (nl - 5'd1);
    rnd     = ({1'b0, base5_r} + half) >> nl;
    npl_raw = rnd << nl;
    npl_nxt = (npl_raw < TOT_W'(3840)) ? TOT_W'(3840) : npl_raw;
  end

  // stage 7: ROM compares and reciprocal estimate of the code-block count
  logic [ROM_LEN-1:0] lt_nxt, lt7_r;
  logic [13:0]        k_c, k7_r;
  logic [14:0]        m_c;
  logic [TOT_W-1:0]   x_c, x7_r, tot7_r;
  logic [40:0]        qp;
  logic [13:0]        q07_r;
  logic               sm7_r, rl7_r, big7_r;

  always_comb begin
    for (int i = 0; i < ROM_LEN; i++) begin
      lt_nxt[i] = TBS_ROM[i] < nps6_r;
    end
    k_c = rl6_r ? 14'd3816 : 14'd8424;
    m_c = rl6_r ? 15'd17586 : 15'd7966;
    x_c = tot6_r + {12'b0, k_c} - TOT_W'(1);
    qp  = {15'b0, x_c} * {26'b0, m_c};
  end

  // stage 8: index count, correct the estimate, form divisor and numerator
  logic [IDX_W-1:0] cnt;
  logic [27:0]      qk;
  logic [NUM_W-1:0] r_c;
  logic [13:0]      c_fix, c_sel;
  logic [DVS_W-1:0] dvs_c;
  div_t             it8_r;

  always_comb begin
    cnt = '0;
    for (int i = 0; i < ROM_LEN; i++) begin
      cnt = cnt + IDX_W'(lt7_r[i]);
    end
    if (cnt > IDX_W'(ROM_LEN - 1)) cnt = IDX_W'(ROM_LEN - 1);
    qk    = {14'b0, q07_r} * {14'b0, k7_r};
    r_c   = {1'b0, x7_r} - qk[NUM_W-1:0];
    c_fix = (r_c >= {13'b0, k7_r}) ? (q07_r + 14'd1) : q07_r;
    c_sel = (rl7_r || big7_r) ? c_fix : 14'd1;
    dvs_c = {c_sel, 3'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else if (en) begin
      v5_r <= in_valid;
      v6_r <= v5_r;
      v7_r <= v6_r;
      v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sm5_r      <= (ninfo <= NINFO_W'(3824));
      rl5_r      <= rate_low;
      ni5_r      <= ninfo;
      base5_r    <= base_c;
      lgs5_r     <= flog2(ninfo);
      lgl5_r     <= flog2(base_c);
      sm6_r      <= sm5_r;
      rl6_r      <= rl5_r;
      big6_r     <= (npl_nxt > TOT_W'(8424));
      nps6_r     <= nps_nxt;
      tot6_r     <= npl_nxt + TOT_W'(24);
      lt7_r      <= lt_nxt;
      k7_r       <= k_c;
      x7_r       <= x_c;
      tot7_r     <= tot6_r;
      q07_r      <= qp[39:26];
      sm7_r      <= sm6_r;
      rl7_r      <= rl6_r;
      big7_r     <= big6_r;
      it8_r.sm    <= sm7_r;
      it8_r.idx   <= cnt;
      it8_r.rem   <= {1'b0, tot7_r} + {10'b0, dvs_c} - NUM_W'(1);
      it8_r.dvs   <= dvs_c;
      it8_r.quo   <= '0;
    end
  end

  assign out_valid = v8_r;
  assign out_item  = it8_r;

endmodule

FILE: hw/rtl/tbs_div.sv
module tbs_div (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  tbs_pkg::div_t in_item,
  output logic          out_valid,
  output tbs_pkg::div_t out_item
);
  import tbs_pkg::*;

  localparam int NSTG = (QUO_W + 1) / 2;

  // one restoring step at quotient bit b
  function automatic div_t dstep(input div_t s, input int b);
    div_t       r;
    logic [27:0] sub;
    r   = s;
    sub = {11'b0, s.dvs} << b;
    if ({1'b0, s.rem} >= sub) begin
      r.rem    = s.rem - sub[NUM_W-1:0];
      r.quo[b] = 1'b1;
    end
    return r;
  endfunction

  logic v_r [0:NSTG-1];
  div_t s_r [0:NSTG-1];

  for (genvar j = 0; j < NSTG; j++) begin : g_stg
    div_t prev, nxt;
    logic vprev;
    if (j == 0) begin : g_first
      assign prev  = in_item;
      assign vprev = in_valid;
    end else begin : g_rest
      assign prev  = s_r[j-1];
      assign vprev = v_r[j-1];
    end
    if (QUO_W - 2 * j >= 2) begin : g_two
      assign nxt = dstep(dstep(prev, QUO_W - 1 - 2 * j), QUO_W - 2 - 2 * j);
    end else begin : g_one
      assign nxt = dstep(prev, 0);
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= vprev;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        s_r[j] <= nxt;
      end
    end
  end

  assign out_valid = v_r[NSTG-1];
  assign out_item  = s_r[NSTG-1];

endmodule

FILE: hw/rtl/nr_transport_block_size_core.sv
// Channel  Handshake             Payload
// in_      in_valid / in_ready   mod_order, code_rate, rb_count, symbol_count,
//                                dmrs_re_per_prb, overhead_re, scaling_shift,
//                                layer_count
// out_     out_valid / out_ready tbs_bits
//
// One grant per cycle enters while in_ready is high; each transaction then
// passes through the 16-stage pipeline (4 front, 4 quantize, 6 divider,
// 2 output). Every stage carries a valid bit that rst_n clears synchronously.
// A stall on out_ready freezes all stages together and drops in_ready, so no
// transaction is lost or repeated; while the output register is empty the
// pipeline keeps moving regardless of out_ready.
module nr_transport_block_size_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_mod_order,
  input  logic [13:0] in_code_rate,
  input  logic [8:0]  in_rb_count,
  input  logic [3:0]  in_symbol_count,
  input  logic [7:0]  in_dmrs_re_per_prb,
  input  logic [5:0]  in_overhead_re,
  input  logic [1:0]  in_scaling_shift,
  input  logic [3:0]  in_layer_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [22:0] out_tbs_bits
);
  import tbs_pkg::*;

  // advance every stage unless a finished result is held
  logic en;
  logic out_valid_r;
  logic [OUT_W-1:0] out_tbs_bits_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // front end: info-bit count
  logic               fr_v, fr_rl;
  logic [NINFO_W-1:0] fr_ninfo;

  tbs_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .en              (en),
    .in_valid        (in_valid),
    .mod_order       (in_mod_order),
    .code_rate       (in_code_rate),
    .rb_count        (in_rb_count),
    .symbol_count    (in_symbol_count),
    .dmrs_re_per_prb (in_dmrs_re_per_prb),
    .overhead_re     (in_overhead_re),
    .scaling_shift   (in_scaling_shift),
    .layer_count     (in_layer_count),
    .out_valid       (fr_v),
    .ninfo           (fr_ninfo),
    .rate_low        (fr_rl)
  );

  // quantize, ROM index, code-block count
  logic qu_v;
  div_t qu_item;

  tbs_quant u_quant (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fr_v),
    .ninfo     (fr_ninfo),
    .rate_low  (fr_rl),
    .out_valid (qu_v),
    .out_item  (qu_item)
  );

  // ceil(total / (8 * C)) over six stages
  logic dv_v;
  div_t dv_item;

  tbs_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (qu_v),
    .in_item   (qu_item),
    .out_valid (dv_v),
    .out_item  (dv_item)
  );

  // final multiply back to a multiple of 8 * C
  logic             f1_v_r, f1_sm_r;
  logic [IDX_W-1:0] f1_idx_r;
  logic [27:0]      f1_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
    end else if (en) begin
      f1_v_r <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_sm_r   <= dv_item.sm;
      f1_idx_r  <= dv_item.idx;
      f1_prod_r <= {11'b0, dv_item.dvs} * {17'b0, dv_item.quo};
    end
  end

  // pick the path, subtract the CRC, saturate
  logic [27:0]      big_c;
  logic [OUT_W-1:0] tbs_nxt;

  always_comb begin
    big_c = f1_prod_r - 28'd24;
    if (f1_sm_r) begin
      tbs_nxt = {11'b0, TBS_ROM[f1_idx_r]};
    end else if (big_c > {5'b0, OUT_MAX}) begin
      tbs_nxt = OUT_MAX;
    end else begin
      tbs_nxt = big_c[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tbs_bits_r <= tbs_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_tbs_bits = out_tbs_bits_r;

`ifndef SYNTHESIS
  a_min_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_tbs_bits >= 23'd24)
    else $error("transport block size below 24");

  a_byte_align: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_tbs_bits != OUT_MAX) |-> out_tbs_bits[2:0] == 3'd0)
    else $error("transport block size not byte aligned");

  a_large_quo: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_v && !dv_item.sm) |-> dv_item.quo != '0)
    else $error("code-block division gave zero quotient");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (f1_v_r && !en) |=> (f1_v_r && $stable(f1_prod_r)))
    else $error("final stage moved during stall");
`endif

endmodule
